/* hdl/hcbd_pkg.sv */
`default_nettype none
package hcbd_pkg;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_LINE    = 3'd1,
      PH_DATA    = 3'd2,
      PH_TRAILER = 3'd3,
      PH_STOP    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      LS_LEAD   = 2'd0,
      LS_DIGITS = 2'd1,
      LS_TRAIL  = 2'd2,
      LS_BAD    = 2'd3
   } line_type;

   typedef enum logic [2:0] {
      ST_RUN   = 3'd0,
      ST_ZERO  = 3'd1,
      ST_BAD   = 3'd2,
      ST_NOHDR = 3'd3,
      ST_SHORT = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       byte_valid;
      logic       body_end;
      status_type end_status;
   } result_type;

   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [1:0] TRAILER_LEN = 2'd2;

   // space, TAB, LF, VT, FF, CR
   function automatic logic is_blank(input logic [7:0] b);
      is_blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   // bit 4 flags a valid hex digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [7:0] d;
      d = 8'h00;
      hex_digit = 5'b0_0000;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = b - 8'h30;
         hex_digit = {1'b1, d[3:0]};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d = b - 8'h57;
         hex_digit = {1'b1, d[3:0]};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d = b - 8'h37;
         hex_digit = {1'b1, d[3:0]};
      end
   endfunction

endpackage
`default_nettype wire

/* hdl/http_chunked_body_decoder_unit.sv */
// Throughput: one byte per cycle while req_stall is low; req_stall is high while the
// skid entry holds a result. The byte-wide state update and the output register with
// its skid entry let req and rsp proceed together.
// Reset (synchronous, active high) clears decoder state and both output entries;
// after each message's last byte the decoder returns to header search on its own.
`default_nettype none
module http_chunked_body_decoder_unit #(
   parameter int SIZE_BITS = 31
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_msg_byte,
   input  wire logic        req_msg_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_body_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_body_end,
   output logic [2:0]       rsp_end_status
);
   import hcbd_pkg::*;

   logic       take;
   logic       has_result;
   logic       full;
   result_type result;
   result_type out_data;

   assign req_stall = full;
   assign take      = req_valid && !full;

   hcbd_core #(
      .SIZE_BITS(SIZE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .msg_byte   (req_msg_byte),
      .msg_last   (req_msg_last),
      .has_result (has_result),
      .result     (result)
   );

   hcbd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (take && has_result),
      .push_data (result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_body_byte  = out_data.body_byte;
   assign rsp_byte_valid = out_data.byte_valid;
   assign rsp_body_end   = out_data.body_end;
   assign rsp_end_status = 3'(out_data.end_status);

endmodule
`default_nettype wire

/* hdl/hcbd_core.sv */
`default_nettype none
module hcbd_core #(
   parameter int SIZE_BITS = 31
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire logic [7:0]         msg_byte,
   input  wire logic               msg_last,
   output logic                    has_result,
   output hcbd_pkg::result_type    result
);
   import hcbd_pkg::*;

   phase_type              phase_ff, phase_in, phase_nx;
   logic [1:0]             hmc_ff, hmc_in, hmc_nx;
   line_type               ls_ff, ls_in, ls_nx;
   logic                   cr_ff, cr_in, cr_nx;
   logic [SIZE_BITS-1:0]   acc_ff, acc_in, acc_nx;
   logic [SIZE_BITS-1:0]   rem_ff, rem_in, rem_nx;
   logic [1:0]             skip_ff, skip_in, skip_nx;
   status_type             reason_ff, reason_in, reason_nx;

   always_comb begin
      logic [7:0]           want;
      line_type             ls1;
      logic [4:0]           hx;
      logic [SIZE_BITS-1:0] rem_dec;
      logic [1:0]           skip_dec;

      phase_nx  = phase_ff;
      hmc_nx    = hmc_ff;
      ls_nx     = ls_ff;
      cr_nx     = cr_ff;
      acc_nx    = acc_ff;
      rem_nx    = rem_ff;
      skip_nx   = skip_ff;
      reason_nx = reason_ff;
      want      = hmc_ff[0] ? CHAR_LF : CHAR_CR;
      ls1       = ls_ff;
      hx        = hex_digit(msg_byte);
      rem_dec   = rem_ff;
      skip_dec  = skip_ff;

      case (phase_ff)
         PH_HEADER: begin
            if (msg_byte == want) begin
               if (hmc_ff == 2'd3) begin
                  hmc_nx   = 2'd0;
                  phase_nx = PH_LINE;
                  ls_nx    = LS_LEAD;
                  cr_nx    = 1'b0;
                  acc_nx   = '0;
               end else begin
                  hmc_nx = hmc_ff + 2'd1;
               end
            end else begin
               hmc_nx = (msg_byte == CHAR_CR) ? 2'd1 : 2'd0;
            end
         end
         PH_LINE: begin
            // a held CR not followed by LF acts as a blank
            if (cr_ff && msg_byte != CHAR_LF && ls_ff == LS_DIGITS) begin
               ls1 = LS_TRAIL;
            end
            if (msg_byte == CHAR_CR) begin
               ls_nx = ls1;
               cr_nx = 1'b1;
            end else if (msg_byte == CHAR_LF && cr_ff) begin
               cr_nx = 1'b0;
               if (ls_ff == LS_DIGITS || ls_ff == LS_TRAIL) begin
                  if (acc_ff == '0) begin
                     phase_nx  = PH_STOP;
                     reason_nx = ST_ZERO;
                  end else begin
                     rem_nx   = acc_ff;
                     phase_nx = PH_DATA;
                  end
               end else begin
                  phase_nx  = PH_STOP;
                  reason_nx = ST_BAD;
               end
            end else begin
               cr_nx = 1'b0;
               ls_nx = ls1;
               if (ls1 != LS_BAD) begin
                  if (is_blank(msg_byte)) begin
                     if (ls1 == LS_DIGITS) ls_nx = LS_TRAIL;
                  end else if (!hx[4] || ls1 == LS_TRAIL) begin
                     ls_nx = LS_BAD;
                  end else if (ls1 == LS_LEAD) begin
                     ls_nx  = LS_DIGITS;
                     acc_nx = SIZE_BITS'(hx[3:0]);
                  end else if (acc_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                     ls_nx = LS_BAD;
                  end else begin
                     acc_nx = {acc_ff[SIZE_BITS-5:0], hx[3:0]};
                  end
               end
            end
         end
         PH_DATA: begin
            if (rem_ff != '0) rem_dec = rem_ff - SIZE_BITS'(1);
            rem_nx = rem_dec;
            if (rem_dec == '0) begin
               phase_nx = PH_TRAILER;
               skip_nx  = TRAILER_LEN;
            end
         end
         PH_TRAILER: begin
            if (skip_ff != 2'd0) skip_dec = skip_ff - 2'd1;
            skip_nx = skip_dec;
            if (skip_dec == 2'd0) begin
               phase_nx = PH_LINE;
               ls_nx    = LS_LEAD;
               cr_nx    = 1'b0;
               acc_nx   = '0;
            end
         end
         default: begin
         end
      endcase

      phase_in  = phase_nx;
      hmc_in    = hmc_nx;
      ls_in     = ls_nx;
      cr_in     = cr_nx;
      acc_in    = acc_nx;
      rem_in    = rem_nx;
      skip_in   = skip_nx;
      reason_in = reason_nx;
      // message done: back to header search
      if (msg_last) begin
         phase_in  = PH_HEADER;
         hmc_in    = 2'd0;
         ls_in     = LS_LEAD;
         cr_in     = 1'b0;
         acc_in    = '0;
         rem_in    = '0;
         skip_in   = 2'd0;
         reason_in = ST_RUN;
      end
   end

   always_comb begin
      has_result        = (phase_ff == PH_DATA) || msg_last;
      result.byte_valid = (phase_ff == PH_DATA);
      result.body_byte  = (phase_ff == PH_DATA) ? msg_byte : 8'h00;
      result.body_end   = msg_last;
      if (!msg_last) begin
         result.end_status = ST_RUN;
      end else if (phase_nx == PH_HEADER) begin
         result.end_status = ST_NOHDR;
      end else if (phase_nx == PH_STOP) begin
         result.end_status = reason_nx;
      end else begin
         result.end_status = ST_SHORT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hmc_ff    <= 2'd0;
         ls_ff     <= LS_LEAD;
         cr_ff     <= 1'b0;
         acc_ff    <= '0;
         rem_ff    <= '0;
         skip_ff   <= 2'd0;
         reason_ff <= ST_RUN;
      end else if (take) begin
         phase_ff  <= phase_in;
         hmc_ff    <= hmc_in;
         ls_ff     <= ls_in;
         cr_ff     <= cr_in;
         acc_ff    <= acc_in;
         rem_ff    <= rem_in;
         skip_ff   <= skip_in;
         reason_ff <= reason_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/hcbd_outbuf.sv */
`default_nettype none
module hcbd_outbuf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire hcbd_pkg::result_type  push_data,
   output logic                       full,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output hcbd_pkg::result_type       out_data
);
   import hcbd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       drain;

   always_comb begin
      drain         = main_valid_ff && !out_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no push while the skid holds a result
         if (drain) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || drain) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule
`default_nettype wire
